@@ hdl/mbca_pkg.sv @@
// Shared constants, types and state codes for the masked bit compress accumulator.
package mbca_pkg;

   localparam int BIN_BITS_DEFAULT = 10;
   localparam int KEY_WIDTH = 64;
   localparam int DATA_WIDTH = 64;
   localparam int INDEX_WIDTH = 10;
   localparam int STAGE_COUNT = 6;
   localparam int STEP_WIDTH = $clog2(STAGE_COUNT);
   localparam int SHIFT_WIDTH = $clog2(KEY_WIDTH);
   localparam logic [KEY_WIDTH-1:0] MASK_RESET = 64'd12;

   localparam logic KIND_ACCUMULATE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef logic [STAGE_COUNT-1:0][KEY_WIDTH-1:0] stage_masks_type;

   typedef enum logic {
      MS_IDLE,
      MS_DERIVE
   } mask_state_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } store_state_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] bin_index;
      logic                   out_of_range;
   } index_info_type;

   typedef struct packed {
      logic                         kind;
      logic signed [DATA_WIDTH-1:0] value;
      index_info_type               info;
   } item_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]       bin_index;
      logic signed [DATA_WIDTH-1:0] bin_total;
      logic                         out_of_range;
   } result_type;

endpackage

@@ hdl/mbca_channels.sv @@
// Handshake channel interfaces for requests, responses and the mask register write.
interface mbca_req_if import mbca_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [KEY_WIDTH-1:0]         key;
   logic signed [DATA_WIDTH-1:0] value;
   logic [INDEX_WIDTH-1:0]       read_bin;

   modport source (output valid, kind, key, value, read_bin, input ready);
   modport sink (input valid, kind, key, value, read_bin, output ready);
endinterface

interface mbca_rsp_if import mbca_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [INDEX_WIDTH-1:0]       bin_index;
   logic signed [DATA_WIDTH-1:0] bin_total;
   logic                         out_of_range;

   modport source (output valid, bin_index, bin_total, out_of_range, input ready);
   modport sink (input valid, bin_index, bin_total, out_of_range, output ready);
endinterface

interface mbca_csr_if import mbca_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KEY_WIDTH-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ hdl/mbca_mask_unit.sv @@
// Mask register and sequencer that derives the six compress stage masks, one per cycle.
module mbca_mask_unit import mbca_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [KEY_WIDTH-1:0] csr_data,
   output logic                 csr_ready,
   output logic                 idle,
   output logic [KEY_WIDTH-1:0] bit_mask,
   output stage_masks_type      stage_masks
);

   mask_state_type         state_ff, state_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [KEY_WIDTH-1:0]   mask_ff, mask_in;
   logic [KEY_WIDTH-1:0]   m_ff, m_in;
   logic [KEY_WIDTH-1:0]   mk_ff, mk_in;
   stage_masks_type        stage_ff, stage_in;
   logic [KEY_WIDTH-1:0]   mp0, mp1, mp2, mp3, mp4, mp5, mv;
   logic [SHIFT_WIDTH-1:0] shamt;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_DERIVE;
         step_ff  <= '0;
         mask_ff  <= MASK_RESET;
         m_ff     <= MASK_RESET;
         mk_ff    <= (~MASK_RESET) << 1;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         mask_ff  <= mask_in;
         m_ff     <= m_in;
         mk_ff    <= mk_in;
      end
      stage_ff <= stage_in;
   end

   always_comb begin
      mp0 = mk_ff ^ (mk_ff << 1);
      mp1 = mp0 ^ (mp0 << 2);
      mp2 = mp1 ^ (mp1 << 4);
      mp3 = mp2 ^ (mp2 << 8);
      mp4 = mp3 ^ (mp3 << 16);
      mp5 = mp4 ^ (mp4 << 32);
      mv = mp5 & m_ff;
      shamt = SHIFT_WIDTH'(1) << step_ff;

      state_in = state_ff;
      step_in  = step_ff;
      mask_in  = mask_ff;
      m_in     = m_ff;
      mk_in    = mk_ff;
      stage_in = stage_ff;

      case (state_ff)
         MS_IDLE: begin
            if (csr_valid) begin
               mask_in  = csr_data;
               m_in     = csr_data;
               mk_in    = (~csr_data) << 1;
               step_in  = '0;
               state_in = MS_DERIVE;
            end
         end
         MS_DERIVE: begin
            stage_in[step_ff] = mv;
            m_in    = (m_ff ^ mv) | (mv >> shamt);
            mk_in   = mk_ff & ~mp5;
            step_in = step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(STAGE_COUNT - 1)) begin
               state_in = MS_IDLE;
            end
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase
   end

   assign csr_ready   = (state_ff == MS_IDLE);
   assign idle        = (state_ff == MS_IDLE);
   assign bit_mask    = mask_ff;
   assign stage_masks = stage_ff;

endmodule

@@ hdl/mbca_compress.sv @@
// Six-stage bit compress network and bin range check for one request item.
module mbca_compress import mbca_pkg::*; #(
   parameter int BIN_BITS = BIN_BITS_DEFAULT
) (
   input  logic                   kind,
   input  logic [KEY_WIDTH-1:0]   key,
   input  logic [INDEX_WIDTH-1:0] read_bin,
   input  logic [KEY_WIDTH-1:0]   bit_mask,
   input  stage_masks_type        stage_masks,
   output logic [BIN_BITS-1:0]    addr,
   output index_info_type         info
);

   logic [KEY_WIDTH-1:0] x;
   logic [KEY_WIDTH-1:0] t;
   logic                 acc_over;
   logic                 read_over;

   always_comb begin
      x = key & bit_mask;
      for (int s = 0; s < STAGE_COUNT; s++) begin
         t = x & stage_masks[s];
         x = (x ^ t) | (t >> (1 << s));
      end
   end

   assign acc_over = |x[KEY_WIDTH-1:BIN_BITS];

   generate
      if (BIN_BITS >= INDEX_WIDTH) begin : g_read_wide
         assign read_over = 1'b0;
      end else begin : g_read_narrow
         assign read_over = |read_bin[INDEX_WIDTH-1:BIN_BITS];
      end
   endgenerate

   always_comb begin
      if (kind == KIND_READ) begin
         addr              = BIN_BITS'(read_bin);
         info.bin_index    = read_bin;
         info.out_of_range = read_over;
      end else begin
         addr              = x[BIN_BITS-1:0];
         info.bin_index    = acc_over ? '0 : x[INDEX_WIDTH-1:0];
         info.out_of_range = acc_over;
      end
   end

endmodule

@@ hdl/mbca_bin_store.sv @@
// Bin memory with clearing pass, read-modify-write stage, forwarding and result register.
module mbca_bin_store import mbca_pkg::*; #(
   parameter int BIN_BITS = BIN_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  logic [BIN_BITS-1:0] in_addr,
   input  item_type            in_item,
   output logic                in_ready,
   input  logic                out_ready,
   output logic                out_valid,
   output result_type          out_result
);

   localparam int DEPTH = 1 << BIN_BITS;

   store_state_type        state_ff, state_in;
   logic [BIN_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic [DATA_WIDTH-1:0]  bin_mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0]  rdata_ff;
   logic                   p1_valid_ff, p1_valid_in;
   item_type               p1_item_ff;
   logic [BIN_BITS-1:0]    p1_addr_ff;
   logic                   fwd_hit_ff;
   logic [DATA_WIDTH-1:0]  fwd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;
   logic                   p1_go;
   logic [DATA_WIDTH-1:0]  old_total;
   logic [DATA_WIDTH-1:0]  sum;
   logic                   item_we;
   logic                   wr_en;
   logic [BIN_BITS-1:0]    wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (in_accept) begin
         p1_item_ff  <= in_item;
         p1_addr_ff  <= in_addr;
         fwd_hit_ff  <= item_we && (p1_addr_ff == in_addr);
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem_ff[wr_addr] <= wr_data;
      end
      if (in_accept) begin
         rdata_ff <= bin_mem_ff[in_addr];
      end
   end

   always_comb begin
      p1_go     = p1_valid_ff && (!rsp_valid_ff || out_ready);
      old_total = fwd_hit_ff ? fwd_data_ff : rdata_ff;
      sum       = old_total + p1_item_ff.value;
      item_we   = p1_go && !p1_item_ff.info.out_of_range;

      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      in_ready    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + BIN_BITS'(1);
            if (&clr_addr_ff) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            wr_en    = item_we;
            wr_addr  = p1_addr_ff;
            wr_data  = (p1_item_ff.kind == KIND_READ) ? '0 : sum;
            in_ready = !p1_valid_ff || p1_go;
         end
         default: begin
            wr_en    = 1'b0;
            wr_addr  = p1_addr_ff;
            wr_data  = sum;
            state_in = ST_CLEAR;
         end
      endcase

      p1_valid_in = in_accept || (p1_valid_ff && !p1_go);

      rsp_valid_in = p1_go || (rsp_valid_ff && !out_ready);
      rsp_in       = rsp_ff;
      if (p1_go) begin
         rsp_in.bin_index    = p1_item_ff.info.bin_index;
         rsp_in.out_of_range = p1_item_ff.info.out_of_range;
         if (p1_item_ff.info.out_of_range) begin
            rsp_in.bin_total = '0;
         end else if (p1_item_ff.kind == KIND_READ) begin
            rsp_in.bin_total = old_total;
         end else begin
            rsp_in.bin_total = sum;
         end
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_result = rsp_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      in_accept |-> (state_ff == ST_RUN))
      else $error("An item was accepted during the clearing pass.");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && (&clr_addr_ff) |=> (state_ff == ST_RUN))
      else $error("The clearing pass did not end after the last bin.");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && !p1_go |=> p1_valid_ff && $stable(p1_addr_ff))
      else $error("A stalled item in the update stage was lost or changed.");

   a_range_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.out_of_range |-> (rsp_ff.bin_total == '0))
      else $error("An out of range result carries a nonzero total.");

endmodule

@@ hdl/masked_bit_compress_accumulate.sv @@
// Top level of the masked bit compress accumulator: mask unit, compress network, bin store.
//
//   Channel   Direction   Contents
//   req_ch    in          kind, key, value, read_bin
//   rsp_ch    out         bin_index, bin_total, out_of_range
//   csr_ch    in          bit_mask write data
//
// One item is accepted per cycle when the result side keeps up and the mask unit is idle; each
// result is registered after its item passes the registered bin memory read and the update stage.
// After reset the bin memory is cleared one bin per cycle, every bin in turn, with req_ch.ready low.
// After reset and after every mask write the mask unit derives the stage masks in turn, with req_ch.ready low.
// A stalled result holds the update stage, which then holds req_ch.ready low.
module masked_bit_compress_accumulate import mbca_pkg::*; #(
   parameter int BIN_BITS = BIN_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   mbca_req_if.sink   req_ch,
   mbca_rsp_if.source rsp_ch,
   mbca_csr_if.sink   csr_ch
);

   logic                 mask_idle;
   logic [KEY_WIDTH-1:0] bit_mask;
   stage_masks_type      stage_masks;
   logic [BIN_BITS-1:0]  addr;
   index_info_type       info;
   item_type             item;
   logic                 store_ready;
   logic                 req_accept;
   result_type           result;

   mbca_mask_unit u_mask_unit (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_ch.valid),
      .csr_data    (csr_ch.data),
      .csr_ready   (csr_ch.ready),
      .idle        (mask_idle),
      .bit_mask    (bit_mask),
      .stage_masks (stage_masks)
   );

   mbca_compress #(
      .BIN_BITS (BIN_BITS)
   ) u_compress (
      .kind        (req_ch.kind),
      .key         (req_ch.key),
      .read_bin    (req_ch.read_bin),
      .bit_mask    (bit_mask),
      .stage_masks (stage_masks),
      .addr        (addr),
      .info        (info)
   );

   assign item.kind  = req_ch.kind;
   assign item.value = req_ch.value;
   assign item.info  = info;

   assign req_ch.ready = store_ready && mask_idle;
   assign req_accept   = req_ch.valid && req_ch.ready;

   mbca_bin_store #(
      .BIN_BITS (BIN_BITS)
   ) u_bin_store (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (req_accept),
      .in_addr    (addr),
      .in_item    (item),
      .in_ready   (store_ready),
      .out_ready  (rsp_ch.ready),
      .out_valid  (rsp_ch.valid),
      .out_result (result)
   );

   assign rsp_ch.bin_index    = result.bin_index;
   assign rsp_ch.bin_total    = result.bin_total;
   assign rsp_ch.out_of_range = result.out_of_range;

endmodule
